>>> sv/assert_macros.svh
// Concurrent checks, sampled on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop on every clock edge.
`define CHK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Hold cons on every edge at which ante is true.
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/ctt_pkg.sv
`default_nettype none

package ctt_pkg;

    localparam int TOKEN_BUFFER_SIZE = 1024;
    localparam int LEN_W             = $clog2(TOKEN_BUFFER_SIZE);
    localparam logic [LEN_W-1:0] TOKEN_CAP = LEN_W'(TOKEN_BUFFER_SIZE - 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_EOS  = 1'b1;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_QUOTED  = 2'd1,
        MODE_COMMENT = 2'd2
    } t_mode;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic       trunc;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0]        count;
        t_result [1:0]     res;
    } t_push;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

`default_nettype wire

>>> sv/ctt_lex.sv
`default_nettype none

module ctt_lex
    import ctt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_action,
    input  wire logic [7:0] i_byte,
    output t_push           o_push
);

`include "assert_macros.svh"

    t_mode            r_mode, n_mode;
    logic             r_esc, n_esc;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_ovf, n_ovf;

    logic       do_a1, do_a2, end_any, end_nz, eos;
    logic [7:0] ch1, ch2;

    always_comb begin
        do_a1   = 1'b0;
        do_a2   = 1'b0;
        end_any = 1'b0;
        end_nz  = 1'b0;
        eos     = 1'b0;
        ch1     = '0;
        ch2     = '0;
        n_mode  = r_mode;
        n_esc   = r_esc;
        if (i_action == ACT_EOS) begin
            eos    = 1'b1;
            do_a1  = r_esc;
            ch1    = CH_BSLASH;
            end_nz = 1'b1;
            n_mode = MODE_NORMAL;
            n_esc  = 1'b0;
        end else begin
            unique case (r_mode)
                MODE_COMMENT: begin
                    if (i_byte == CH_NL) begin
                        n_mode = MODE_NORMAL;
                    end
                end
                MODE_QUOTED: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        do_a1 = 1'b1;
                        if (i_byte == CH_QUOTE) begin
                            ch1 = CH_QUOTE;
                        end else begin
                            ch1 = CH_BSLASH;
                            if (i_byte == CH_BSLASH) begin
                                n_esc = 1'b1;
                            end else begin
                                do_a2 = 1'b1;
                                ch2   = i_byte;
                            end
                        end
                    end else if (i_byte == CH_QUOTE) begin
                        end_any = 1'b1;
                        n_mode  = MODE_NORMAL;
                    end else if (i_byte == CH_BSLASH) begin
                        n_esc = 1'b1;
                    end else begin
                        do_a1 = 1'b1;
                        ch1   = i_byte;
                    end
                end
                default: begin
                    if (i_byte == CH_QUOTE) begin
                        end_nz = 1'b1;
                        n_mode = MODE_QUOTED;
                        n_esc  = 1'b0;
                    end else if (is_space(i_byte)) begin
                        end_nz = 1'b1;
                    end else if (i_byte == CH_EQ) begin
                        end_nz = 1'b1;
                        do_a2  = 1'b1;
                        ch2    = CH_EQ;
                    end else if (i_byte == CH_HASH) begin
                        end_nz = 1'b1;
                        n_mode = MODE_COMMENT;
                    end else begin
                        do_a1 = 1'b1;
                        ch1   = i_byte;
                    end
                end
            endcase
        end
    end

    // Character, token end, character: the order in which they may occur.
    logic [1:0]    cnt;
    t_result [1:0] res;

    always_comb begin
        n_len = r_len;
        n_ovf = r_ovf;
        cnt   = 2'd0;
        res   = '0;
        if (do_a1) begin
            if (n_len < TOKEN_CAP) begin
                n_len             = n_len + 1'b1;
                res[cnt[0]].kind  = KIND_CHAR;
                res[cnt[0]].ch    = ch1;
                cnt               = cnt + 2'd1;
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (end_any || (end_nz && (n_len != '0))) begin
            res[cnt[0]].kind  = KIND_END;
            res[cnt[0]].trunc = n_ovf;
            cnt               = cnt + 2'd1;
            n_len             = '0;
            n_ovf             = 1'b0;
        end
        if (do_a2) begin
            if (n_len < TOKEN_CAP) begin
                n_len             = n_len + 1'b1;
                res[cnt[0]].kind  = KIND_CHAR;
                res[cnt[0]].ch    = ch2;
                cnt               = cnt + 2'd1;
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (eos) begin
            n_len = '0;
            n_ovf = 1'b0;
        end
        if (cnt == 2'd1) begin
            res[0].last = 1'b1;
        end else if (cnt == 2'd2) begin
            res[1].last = 1'b1;
        end
    end

    always_comb begin
        o_push.count = i_accept ? cnt : 2'd0;
        o_push.res   = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_esc  <= 1'b0;
            r_len  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_esc  <= n_esc;
            r_len  <= n_len;
            r_ovf  <= n_ovf;
        end
    end

    `CHK(lex_len_cap, r_len <= TOKEN_CAP, "token length beyond cap")
    `CHK_IMPL(lex_ovf_full, r_ovf, r_len == TOKEN_CAP, "overflow flag on a short token")
    `CHK_IMPL(lex_esc_quoted, r_esc, r_mode == MODE_QUOTED, "escape outside quotes")

endmodule

`default_nettype wire

>>> sv/ctt_outq.sv
`default_nettype none

module ctt_outq
    import ctt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_ready,
    output logic       o_valid,
    input  wire logic  i_pop_ready,
    output t_result    o_res
);

`include "assert_macros.svh"

    t_result           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_head, r_tail;
    logic [QCNT_W-1:0] r_count;
    logic              pop;

    assign o_ready = r_count <= QCNT_W'(QDEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_res   = r_mem[r_head];
    assign pop     = o_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (pop) begin
                r_head <= r_head + 1'b1;
            end
            r_tail  <= r_tail + QPTR_W'(i_push.count);
            r_count <= r_count + QCNT_W'(i_push.count) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_tail] <= i_push.res[0];
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_tail + 1'b1] <= i_push.res[1];
        end
    end

    `CHK(outq_count_max, r_count <= QCNT_W'(QDEPTH), "result queue count beyond depth")
    `CHK(outq_ptr_track, QPTR_W'(r_tail - r_head) == r_count[QPTR_W-1:0],
         "result queue pointers disagree with count")
    `CHK_IMPL(outq_no_overrun, i_push.count != 2'd0, r_count <= QCNT_W'(QDEPTH - 2),
              "push into a result queue without room")

endmodule

`default_nettype wire

>>> sv/config_text_tokenizer.sv
// Latency: a request's first result is offered on the cycle after it is accepted
// if the queue holds none. Throughput: one text byte per cycle while each byte
// yields at most one result and m_axis_tready holds no result back; the second
// result of a byte is absorbed by a four-entry result queue that sets the input ready.
// Reset (synchronous, active low): lexer back to normal mode, empty token, queue empty.
`default_nettype none

module config_text_tokenizer
    import ctt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,  // [7:0] text_byte
    input  wire logic [0:0] s_axis_tuser,  // [0] action
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,  // [7:0] token_char
    output logic [1:0]      m_axis_tuser,  // [0] kind, [1] truncated
    output logic            m_axis_tlast
);

    logic    accept;
    t_push   push;
    t_result head;

    assign accept = s_axis_tvalid && s_axis_tready;

    ctt_lex u_lex (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_action (s_axis_tuser[0]),
        .i_byte   (s_axis_tdata),
        .o_push   (push)
    );

    ctt_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_res       (head)
    );

    assign m_axis_tdata = head.ch;
    assign m_axis_tuser = {head.trunc, head.kind};
    assign m_axis_tlast = head.last;

endmodule

`default_nettype wire
